// File: hdl/cdf_pkg.sv
// Package for the inverse-CDF bin lookup: table geometry, result codes,
// sequencer step codes and the microcode table. No dependencies.
package cdf_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 11;
    localparam int VAL_W       = 32;
    localparam int BIN_W       = 10;
    localparam int EDGE_W      = 2;
    localparam int STEP_W      = 3;

    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1024);

    localparam logic [EDGE_W-1:0] EDGE_INSIDE = 2'd0;
    localparam logic [EDGE_W-1:0] EDGE_FIRST  = 2'd1;
    localparam logic [EDGE_W-1:0] EDGE_LAST   = 2'd2;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // sequencer steps
    localparam logic [STEP_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] ST_RD0   = 3'd1;
    localparam logic [STEP_W-1:0] ST_CHK0  = 3'd2;
    localparam logic [STEP_W-1:0] ST_CHKN  = 3'd3;
    localparam logic [STEP_W-1:0] ST_SPAN  = 3'd4;
    localparam logic [STEP_W-1:0] ST_CMP   = 3'd5;
    localparam logic [STEP_W-1:0] ST_EMIT  = 3'd6;

    // read address select
    localparam logic [1:0] RD_NONE = 2'd0;
    localparam logic [1:0] RD_ZERO = 2'd1;
    localparam logic [1:0] RD_LAST = 2'd2;
    localparam logic [1:0] RD_MID  = 2'd3;

    // datapath operation / condition source
    localparam logic [2:0] OP_IDLE  = 3'd0;
    localparam logic [2:0] OP_NONE  = 3'd1;
    localparam logic [2:0] OP_FIRST = 3'd2;
    localparam logic [2:0] OP_LAST  = 3'd3;
    localparam logic [2:0] OP_SPAN  = 3'd4;
    localparam logic [2:0] OP_CMP   = 3'd5;
    localparam logic [2:0] OP_EMIT  = 3'd6;

    typedef struct packed {
        logic [1:0]        rd_sel;
        logic [2:0]        op;
        logic [STEP_W-1:0] seq_next;  // taken when condition is false
        logic [STEP_W-1:0] jmp;       // taken when condition is true
    } t_ctrl;

    function automatic t_ctrl ucode(input logic [STEP_W-1:0] step);
        t_ctrl w;
        w = '{rd_sel: RD_NONE, op: OP_IDLE, seq_next: ST_IDLE, jmp: ST_RD0};
        unique case (step)
            ST_IDLE: w = '{rd_sel: RD_NONE, op: OP_IDLE,  seq_next: ST_IDLE, jmp: ST_RD0};
            ST_RD0:  w = '{rd_sel: RD_ZERO, op: OP_NONE,  seq_next: ST_CHK0, jmp: ST_CHK0};
            ST_CHK0: w = '{rd_sel: RD_LAST, op: OP_FIRST, seq_next: ST_CHKN, jmp: ST_EMIT};
            ST_CHKN: w = '{rd_sel: RD_NONE, op: OP_LAST,  seq_next: ST_SPAN, jmp: ST_EMIT};
            ST_SPAN: w = '{rd_sel: RD_MID,  op: OP_SPAN,  seq_next: ST_CMP,  jmp: ST_EMIT};
            ST_CMP:  w = '{rd_sel: RD_NONE, op: OP_CMP,   seq_next: ST_SPAN, jmp: ST_SPAN};
            ST_EMIT: w = '{rd_sel: RD_NONE, op: OP_EMIT,  seq_next: ST_EMIT, jmp: ST_IDLE};
            default: w = '{rd_sel: RD_NONE, op: OP_IDLE,  seq_next: ST_IDLE, jmp: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: hdl/cdf_bin_lookup_bisection.sv
// Inverse-CDF bin lookup by bisection over the table; depends on cdf_pkg.
// A load is one transfer per cycle while idle. A query result is registered on a first-bin
// clamp, a last-bin clamp, or after bisection by halvings (midpoint read, then compare);
// emit waits for the output, then the sequencer returns to idle for the next transfer.
// Reset (sync, active low) clears the sequencer and output valid and sets
// entries in use to 1024; table contents are undefined until written.
module cdf_bin_lookup_bisection (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [9:0] entry_index, [41:10] sample_value
    input  logic [0:0]  s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] bin_index
    output logic [1:0]  m_axis_tuser,   // [1:0] edge_case
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data      // entries_in_use
);

    logic [cdf_pkg::VAL_W-1:0] mem [cdf_pkg::TABLE_DEPTH];

    logic [cdf_pkg::STEP_W-1:0] r_step, n_step;
    logic [cdf_pkg::CNT_W-1:0]  r_entries;
    logic [cdf_pkg::VAL_W-1:0]  r_x, r_rdata;
    logic [cdf_pkg::IDX_W-1:0]  r_lo, r_hi, r_mid, n_lo, n_hi;
    logic [cdf_pkg::BIN_W-1:0]  r_bin, n_bin, r_m_bin;
    logic [cdf_pkg::EDGE_W-1:0] r_edge, n_edge, r_m_edge;
    logic                       r_m_valid;

    cdf_pkg::t_ctrl            w_ctrl;
    logic                      w_in_xfer, w_cond, w_out_free;
    logic [cdf_pkg::IDX_W-1:0] w_last, w_span, w_mid, w_rd_addr;
    logic [cdf_pkg::IDX_W-1:0] w_ld_idx;
    logic [cdf_pkg::VAL_W-1:0] w_ld_val;

    assign w_ctrl = cdf_pkg::ucode(r_step);

    assign s_axis_tready = (r_step == cdf_pkg::ST_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_ld_idx      = s_axis_tdata[9:0];
    assign w_ld_val      = s_axis_tdata[41:10];

    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'd0, r_m_bin};
    assign m_axis_tuser  = r_m_edge;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    // last entry in use, with zero treated as one and saturation at depth
    always_comb begin
        if (r_entries == '0) begin
            w_last = '0;
        end else if (r_entries > cdf_pkg::CNT_W'(cdf_pkg::TABLE_DEPTH)) begin
            w_last = cdf_pkg::IDX_W'(cdf_pkg::TABLE_DEPTH - 1);
        end else begin
            w_last = cdf_pkg::IDX_W'(r_entries - 1'b1);
        end
    end

    assign w_span = r_hi - r_lo;
    assign w_mid  = r_lo + (w_span >> 1);

    always_comb begin
        case (w_ctrl.rd_sel)
            cdf_pkg::RD_ZERO: w_rd_addr = '0;
            cdf_pkg::RD_LAST: w_rd_addr = w_last;
            default:          w_rd_addr = w_mid;
        endcase
    end

    // datapath operation and condition
    always_comb begin
        w_cond = 1'b0;
        n_lo   = r_lo;
        n_hi   = r_hi;
        n_bin  = r_bin;
        n_edge = r_edge;
        unique case (w_ctrl.op)
            cdf_pkg::OP_IDLE: begin
                w_cond = w_in_xfer && (s_axis_tuser[0] == cdf_pkg::MODE_QUERY);
            end
            cdf_pkg::OP_NONE: begin
                w_cond = 1'b0;
            end
            cdf_pkg::OP_FIRST: begin
                w_cond = (r_x <= r_rdata);
                n_bin  = '0;
                n_edge = cdf_pkg::EDGE_FIRST;
            end
            cdf_pkg::OP_LAST: begin
                w_cond = (r_x >= r_rdata);
                n_bin  = cdf_pkg::BIN_W'(w_last);
                n_edge = cdf_pkg::EDGE_LAST;
                n_lo   = '0;
                n_hi   = w_last;
            end
            cdf_pkg::OP_SPAN: begin
                w_cond = (w_span <= cdf_pkg::IDX_W'(1));
                n_bin  = cdf_pkg::BIN_W'(r_hi);
                n_edge = cdf_pkg::EDGE_INSIDE;
            end
            cdf_pkg::OP_CMP: begin
                w_cond = 1'b0;
                if (r_x < r_rdata) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid;
                end
            end
            cdf_pkg::OP_EMIT: begin
                w_cond = w_out_free;
            end
            default: begin
                w_cond = 1'b0;
            end
        endcase
        n_step = w_cond ? w_ctrl.jmp : w_ctrl.seq_next;
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer && (s_axis_tuser[0] == cdf_pkg::MODE_LOAD)) begin
            mem[w_ld_idx] <= w_ld_val;
        end
        if (w_ctrl.rd_sel != cdf_pkg::RD_NONE) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_x <= w_ld_val;
        end
        if (w_ctrl.rd_sel == cdf_pkg::RD_MID) begin
            r_mid <= w_mid;
        end
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_bin  <= n_bin;
        r_edge <= n_edge;
        if ((w_ctrl.op == cdf_pkg::OP_EMIT) && w_out_free) begin
            r_m_bin  <= r_bin;
            r_m_edge <= r_edge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= cdf_pkg::ST_IDLE;
            r_entries <= cdf_pkg::CNT_RESET;
            r_m_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (i_cfg_valid && o_cfg_ready) begin
                r_entries <= i_cfg_data;
            end
            if ((w_ctrl.op == cdf_pkg::OP_EMIT) && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

endmodule
